// File: src/ab2lp_pkg.sv
// ----------------------------------------------------------------------------
// ab2lp_pkg
// Shared constants, types and width helpers for the Annex-B to
// length-prefixed NAL rewriter.
// ----------------------------------------------------------------------------
`default_nettype none

package ab2lp_pkg;

   // Output buffer size in bytes
   localparam int unsigned BUF_BYTES = 32'd4194304;

   // Counter width that holds 0 .. BUF_BYTES, and one more bit for sums
   localparam int CNT_W = $clog2(BUF_BYTES) + 1;
   localparam int SUM_W = CNT_W + 1;

   // Fixed field widths
   localparam int ADDR_W = 22;
   localparam int ULEN_W = 23;
   localparam int WORD_W = 32;

   localparam logic [CNT_W-1:0] BUF_CNT = CNT_W'(BUF_BYTES);
   localparam logic [SUM_W-1:0] BUF_SUM = SUM_W'(BUF_BYTES);

   // NAL header fields
   localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
   localparam logic [7:0] NAL_TYPE_SPS  = 8'd7;
   localparam logic [7:0] NAL_TYPE_PPS  = 8'd8;

   // Start code pieces
   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] BYTE_SC_END   = 8'h01;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_NAL   = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // NAL types that stay in the output stream
   function automatic logic nal_is_kept(input logic [7:0] first_byte);
      logic [7:0] nal_type;
      nal_type = first_byte & NAL_TYPE_MASK;
      return (nal_type != NAL_TYPE_SPS) && (nal_type != NAL_TYPE_PPS);
   endfunction

   // Low bits of a sum as a buffer address
   function automatic logic [ADDR_W-1:0] sum_to_addr(input logic [SUM_W-1:0] v);
      logic [SUM_W+ADDR_W-1:0] wide;
      wide = {{ADDR_W{1'b0}}, v};
      return wide[ADDR_W-1:0];
   endfunction

   // Low bits of a count as a unit length
   function automatic logic [ULEN_W-1:0] cnt_to_ulen(input logic [CNT_W-1:0] v);
      logic [CNT_W+ULEN_W-1:0] wide;
      wide = {{ULEN_W{1'b0}}, v};
      return wide[ULEN_W-1:0];
   endfunction

   // Count as a 32-bit length prefix
   function automatic logic [WORD_W-1:0] cnt_to_word(input logic [CNT_W-1:0] v);
      logic [CNT_W+WORD_W-1:0] wide;
      wide = {{WORD_W{1'b0}}, v};
      return wide[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/annexb_to_length_prefixed_nal.sv
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal
// Rewrites an Annex-B access unit, one byte per item, into buffer writes of
// length-prefixed NAL units, and reports the unit total on its last result.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  req     | in        | req_valid/req_stall  | data_byte, last_of_unit
//  rsp     | out       | rsp_valid/rsp_stall  | write_valid/address/data,
//          |           |                      | unit_done/length/status
//
//  An input byte is decoded in the cycle it is taken; its zero to eight
//  results land in a result stage and leave one per cycle while rsp_stall is low.
//  One result per byte sustains one byte per cycle; a byte with more results
//  stalls the input until its last one leaves the single-result output port.
//  Reset is synchronous and clears parser state and the result pointer only.
//  A stalled result holds; the input stalls until the stage drains its last.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_to_length_prefixed_nal
   import ab2lp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_last_of_unit,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_write_valid,
   output logic [ADDR_W-1:0]       rsp_write_address,
   output logic [7:0]              rsp_write_data,
   output logic                    rsp_unit_done,
   output logic [ULEN_W-1:0]       rsp_unit_length,
   output logic [1:0]              rsp_unit_status
);

   // Parser state
   logic             inside_ff,  inside_in;
   logic [1:0]       held_ff,    held_in;
   logic [CNT_W-1:0] hbase_ff,   hbase_in;
   logic [CNT_W-1:0] nbc_ff,     nbc_in;
   logic             kept_ff,    kept_in;
   logic             ovf_ff,     ovf_in;

   // Result stage
   logic [3:0]        rem_ff,    rem_in;
   logic [2:0]        pos_ff,    pos_in;
   logic [2:0]        s_m_ff;
   logic [ADDR_W-1:0] s_dbase_ff;
   logic [7:0]        s_data_ff [4];
   logic              s_hdr_ff;
   logic [ADDR_W-1:0] s_hbase_ff;
   logic [WORD_W-1:0] s_len_ff;
   logic              s_done_ff;
   logic [ULEN_W-1:0] s_ulen_ff;
   status_type        s_status_ff;

   // Decode signals
   logic              acc, drain;
   logic              case_zero, case_sc, case_other;
   logic [1:0]        held_after;
   logic [2:0]        n_pre, n_calls, n_minus1;
   logic [7:0]        wr_byte [4];
   logic              first_call, kept_eff, kept_new;
   logic [SUM_W-1:0]  addr0;
   logic [2:0]        m_cnt;
   logic              ovf_new;
   logic [CNT_W:0]    nbc_sum;
   logic [CNT_W-1:0]  nbc_new;
   logic              do_end, hdr;
   logic [SUM_W-1:0]  hbase_sum;
   logic [CNT_W-1:0]  hbase_end;
   logic              idle_res;
   logic [3:0]        total;
   status_type        status_new;
   logic [ULEN_W-1:0] ulen_new;
   logic [2:0]        hdr_pos;
   logic [WORD_W-1:0] len_shift;

   assign acc   = req_valid && !req_stall;
   assign drain = rsp_valid && !rsp_stall;

   // Hold the input while more than the result now leaving is queued
   assign req_stall = (rem_ff > 4'd1) || ((rem_ff == 4'd1) && rsp_stall);
   assign rsp_valid = (rem_ff != 4'd0);

   // Classify the byte: zero, start code end, or ordinary data
   always_comb begin
      case_zero  = (req_data_byte == BYTE_ZERO);
      case_sc    = (req_data_byte == BYTE_SC_END) && (held_ff >= 2'd2);
      case_other = !case_zero && !case_sc;

      // Zeros still held after this byte, and NAL bytes released by it
      held_after = 2'd0;
      n_pre      = 3'd0;
      if (case_zero) begin
         held_after = (held_ff == 2'd3) ? 2'd3 : held_ff + 2'd1;
         n_pre      = (held_ff == 2'd3) ? 3'd1 : 3'd0;
      end else if (case_other) begin
         n_pre = {1'b0, held_ff} + 3'd1;
      end

      // Unit end flushes the held zeros into the NAL
      n_calls = 3'd0;
      if (inside_ff) begin
         n_calls = n_pre + (req_last_of_unit ? {1'b0, held_after} : 3'd0);
      end
      n_minus1 = n_calls - 3'd1;

      // Released bytes are zeros, the ordinary byte comes last
      for (int k = 0; k < 4; k++) begin
         wr_byte[k] = (case_other && (n_minus1 == 3'(k))) ? req_data_byte : BYTE_ZERO;
      end

      // The first byte of a NAL decides whether it is kept
      first_call = (nbc_ff == '0) && (n_calls != 3'd0);
      kept_eff   = first_call ? nal_is_kept(wr_byte[0]) : kept_ff;
      kept_new   = (n_calls != 3'd0) ? kept_eff : kept_ff;

      // Count the data writes that still fit the buffer
      addr0 = SUM_W'(hbase_ff) + SUM_W'(nbc_ff) + SUM_W'(4);
      m_cnt = 3'd0;
      for (int k = 0; k < 4; k++) begin
         if (kept_eff && !ovf_ff && (3'(k) < n_calls) &&
             ((addr0 + SUM_W'(k)) < BUF_SUM)) begin
            m_cnt = m_cnt + 3'd1;
         end
      end
      ovf_new = ovf_ff || (kept_eff && (m_cnt != n_calls));

      // Advance the NAL byte count, saturating at the buffer size
      nbc_sum = {1'b0, nbc_ff} + (CNT_W+1)'(n_calls);
      nbc_new = (nbc_sum > {1'b0, BUF_CNT}) ? BUF_CNT : nbc_sum[CNT_W-1:0];

      // Close the NAL on a start code or at unit end
      do_end    = inside_ff && (case_sc || req_last_of_unit);
      hdr       = do_end && kept_new && (nbc_new != '0) && !ovf_new;
      hbase_sum = SUM_W'(hbase_ff) + SUM_W'(nbc_new) + SUM_W'(4);
      hbase_end = hdr ? hbase_sum[CNT_W-1:0] : hbase_ff;

      // Unit summary
      if (ovf_new) begin
         status_new = STATUS_OVERFLOW;
         ulen_new   = '0;
      end else if (hbase_end == '0) begin
         status_new = STATUS_NO_NAL;
         ulen_new   = '0;
      end else begin
         status_new = STATUS_OK;
         ulen_new   = cnt_to_ulen(hbase_end);
      end

      idle_res = req_last_of_unit && (m_cnt == 3'd0) && !hdr;
      total    = {1'b0, m_cnt} + (hdr ? 4'd4 : 4'd0) + (idle_res ? 4'd1 : 4'd0);
   end

   // Next parser state
   always_comb begin
      inside_in = inside_ff;
      held_in   = held_ff;
      hbase_in  = hbase_ff;
      nbc_in    = nbc_ff;
      kept_in   = kept_ff;
      ovf_in    = ovf_ff;
      if (acc) begin
         if (req_last_of_unit) begin
            inside_in = 1'b0;
            held_in   = 2'd0;
            hbase_in  = '0;
            nbc_in    = '0;
            kept_in   = 1'b0;
            ovf_in    = 1'b0;
         end else begin
            inside_in = inside_ff || case_sc;
            held_in   = held_after;
            hbase_in  = hbase_end;
            nbc_in    = case_sc ? '0 : nbc_new;
            kept_in   = case_sc ? 1'b0 : kept_new;
            ovf_in    = ovf_new;
         end
      end
   end

   // Advance the result pointer, reload on a new item
   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      if (acc) begin
         rem_in = total;
         pos_in = 3'd0;
      end else if (drain) begin
         rem_in = rem_ff - 4'd1;
         pos_in = pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         held_ff   <= 2'd0;
         hbase_ff  <= '0;
         nbc_ff    <= '0;
         kept_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         rem_ff    <= 4'd0;
         pos_ff    <= 3'd0;
      end else begin
         inside_ff <= inside_in;
         held_ff   <= held_in;
         hbase_ff  <= hbase_in;
         nbc_ff    <= nbc_in;
         kept_ff   <= kept_in;
         ovf_ff    <= ovf_in;
         rem_ff    <= rem_in;
         pos_ff    <= pos_in;
      end
   end

   // Load the result stage payload
   always_ff @(posedge clock) begin
      if (acc) begin
         s_m_ff      <= m_cnt;
         s_dbase_ff  <= sum_to_addr(addr0);
         s_data_ff   <= wr_byte;
         s_hdr_ff    <= hdr;
         s_hbase_ff  <= sum_to_addr(SUM_W'(hbase_ff));
         s_len_ff    <= cnt_to_word(nbc_new);
         s_done_ff   <= req_last_of_unit;
         s_ulen_ff   <= ulen_new;
         s_status_ff <= status_new;
      end
   end

   // Select the result at the current position
   always_comb begin
      hdr_pos           = pos_ff - s_m_ff;
      len_shift         = s_len_ff >> {(2'd3 - hdr_pos[1:0]), 3'b000};
      rsp_write_valid   = 1'b0;
      rsp_write_address = '0;
      rsp_write_data    = 8'd0;
      if (pos_ff < s_m_ff) begin
         rsp_write_valid   = 1'b1;
         rsp_write_address = s_dbase_ff + ADDR_W'(pos_ff);
         rsp_write_data    = s_data_ff[pos_ff[1:0]];
      end else if (s_hdr_ff) begin
         rsp_write_valid   = 1'b1;
         rsp_write_address = s_hbase_ff + ADDR_W'(hdr_pos[1:0]);
         rsp_write_data    = len_shift[7:0];
      end
      rsp_unit_done   = s_done_ff && (rem_ff == 4'd1);
      rsp_unit_length = rsp_unit_done ? s_ulen_ff : '0;
      rsp_unit_status = rsp_unit_done ? s_status_ff : STATUS_OK;
   end

endmodule

`default_nettype wire
